/* src/order_preserving_factorize_assert.svh */
// assertion macros used by the checker file
`ifndef ORDER_PRESERVING_FACTORIZE_ASSERT_SVH
`define ORDER_PRESERVING_FACTORIZE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define OPF_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("opf check failed");

// same-cycle implication
`define OPF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("opf check failed");

// next-cycle implication
`define OPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("opf check failed");

`endif

/* src/opf_pkg.sv */
// types and control encodings for the order-preserving factoriser
package opf_pkg;

    typedef struct packed {
        logic signed [31:0] element;
        logic               last_element;
    } elem_word_t;

    typedef struct packed {
        logic [7:0]         lookup_index;
        logic               is_new;
        logic signed [31:0] new_element;
        logic               table_full;
        logic [8:0]         unique_count;
        logic               last_result;
    } res_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } opf_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } opf_cmd_t;

    typedef struct packed {
        logic empty;
        logic hit;
        logic miss_done;
        logic res_free;
    } opf_status_t;

endpackage

/* src/order_preserving_factorize.sv */
// order-preserving factoriser: dictionary encoding of one array at a time
//
// elem channel: one word per array element, with last_element marking the end.
// res channel: one word per element giving its index in the table of distinct
// values (first-appearance order); is_new words rebuild the unique array.
// a new value meeting a full table gives table_full, index 0, no insert.
// a word's result waits on a linear scan over the table ram (one read per
// cycle) that stops at a hit or after the last filled entry; an empty table
// skips the scan. the next word can be taken in the cycle after the result
// is loaded, so the block works on one word at a time.
// the result register frees the input side: a new word is taken while the
// previous result still waits; a stalled result holds, and the scan finishes
// but waits for the result register before writing.
// reset clears the fill count; the table ram needs no clearing pass since only
// the filled entries are read. after the last word's result the count returns
// to zero for the next array.
module order_preserving_factorize #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                elem_valid,
    output logic                elem_stall,
    input  opf_pkg::elem_word_t elem,
    output logic                res_valid,
    input  logic                res_stall,
    output opf_pkg::res_word_t  res
);

    opf_pkg::opf_cmd_t    cmd;
    opf_pkg::opf_status_t status;

    opf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .elem_valid(elem_valid),
        .elem_stall(elem_stall),
        .status    (status),
        .cmd       (cmd)
    );

    opf_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .elem     (elem),
        .cmd      (cmd),
        .status   (status),
        .res      (res),
        .res_valid(res_valid),
        .res_stall(res_stall)
    );

endmodule

/* src/opf_ram.sv */
// generic simple dual-port ram with registered read
module opf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/opf_ctrl.sv */
// sequencer: accept, scan the table, then hand over the result
module opf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                elem_valid,
    output logic                elem_stall,
    input  opf_pkg::opf_status_t status,
    output opf_pkg::opf_cmd_t    cmd
);

    opf_pkg::opf_state_t state_reg;
    opf_pkg::opf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= opf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        elem_stall = 1'b1;
        case (state_reg)
            opf_pkg::ST_IDLE:
            begin
                elem_stall = 1'b0;
                if (elem_valid)
                begin
                    cmd.load = 1'b1;
                    // empty table: nothing to compare against
                    state_next = status.empty ? opf_pkg::ST_FINISH : opf_pkg::ST_SCAN;
                end
            end
            opf_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.hit || status.miss_done)
                begin
                    state_next = opf_pkg::ST_FINISH;
                end
            end
            opf_pkg::ST_FINISH:
            begin
                if (status.res_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = opf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = opf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* src/opf_datapath.sv */
// table store, scan pointer, compare and result register
module opf_datapath #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  opf_pkg::elem_word_t  elem,
    input  opf_pkg::opf_cmd_t    cmd,
    output opf_pkg::opf_status_t status,
    output opf_pkg::res_word_t   res,
    output logic                 res_valid,
    input  logic                 res_stall
);

    localparam int AW = $clog2(TABLE_DEPTH > 1 ? TABLE_DEPTH : 2);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] pidx_reg, pidx_next;
    logic          pend_reg, pend_next;
    logic          found_reg, found_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [31:0]   value_reg, value_next;
    logic          last_reg, last_next;
    logic          res_valid_reg, res_valid_next;
    opf_pkg::res_word_t res_reg, res_next;

    logic          issue;
    logic          match;
    logic          insert;
    logic [CW-1:0] cnt_after;
    logic [CW-1:0] pos_out;
    logic [CW+8:0] cnt_ext;
    logic [CW+7:0] pos_ext;
    logic [31:0]   rdata;

    opf_ram #(
        .WIDTH(32),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (cmd.finish && insert),
        .waddr(count_reg[AW-1:0]),
        .wdata(value_reg),
        .raddr(ptr_reg[AW-1:0]),
        .rdata(rdata)
    );

    // one read issued per cycle, data compared in the cycle after the read
    assign issue = cmd.scan && (ptr_reg < count_reg);
    assign match = (rdata == value_reg);

    assign status.empty     = (count_reg == '0);
    assign status.hit       = pend_reg && match;
    assign status.miss_done = pend_reg && !match && (CW'(pidx_reg + 1'b1) == count_reg);
    assign status.res_free  = !res_valid_reg || !res_stall;

    assign insert    = !found_reg && (count_reg != DEPTH_C);
    assign cnt_after = insert ? CW'(count_reg + 1'b1) : count_reg;
    assign pos_out   = found_reg ? pos_reg : (insert ? count_reg : '0);
    assign cnt_ext   = {9'b0, cnt_after};
    assign pos_ext   = {8'b0, pos_out};

    always_comb
    begin
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        pidx_next      = ptr_reg;
        pend_next      = issue;
        found_next     = found_reg;
        pos_next       = pos_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            value_next = elem.element;
            last_next  = elem.last_element;
            ptr_next   = '0;
            found_next = 1'b0;
        end

        if (issue)
        begin
            ptr_next = CW'(ptr_reg + 1'b1);
        end

        if (cmd.scan && status.hit)
        begin
            found_next = 1'b1;
            pos_next   = pidx_reg;
        end

        if (cmd.finish)
        begin
            res_next.lookup_index = pos_ext[7:0];
            res_next.is_new       = insert;
            res_next.new_element  = value_reg;
            res_next.table_full   = !found_reg && !insert;
            res_next.unique_count = cnt_ext[8:0];
            res_next.last_result  = last_reg;
            res_valid_next        = 1'b1;
            // the array's final word empties the table afterwards
            count_next            = last_reg ? '0 : cnt_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg  <= pidx_next;
        pos_reg   <= pos_next;
        value_reg <= value_next;
        last_reg  <= last_next;
        res_reg   <= res_next;
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

/* src/opf_checker.sv */
// port-level checks for the factoriser and their binding
`include "order_preserving_factorize_assert.svh"

module opf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                elem_valid,
    input logic                elem_stall,
    input opf_pkg::elem_word_t elem,
    input logic                res_valid,
    input logic                res_stall,
    input opf_pkg::res_word_t  res
);

    // a value is either appended or dropped, never both
    `OPF_ASSERT_ALWAYS(a_new_xor_full, !(res_valid && res.is_new && res.table_full))

    // an appended value sits at the end of the table
    `OPF_ASSERT_IMPL(a_new_at_end, res_valid && res.is_new, res.lookup_index == 8'(res.unique_count - 9'd1))

    // a dropped value reports index zero
    `OPF_ASSERT_IMPL(a_full_index, res_valid && res.table_full, res.lookup_index == 8'd0)

    // a stalled result word holds
    `OPF_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

endmodule

bind order_preserving_factorize opf_checker u_checker (.*);

/* verif/testbench.sv */
// testbench for the order-preserving factoriser: random arrays against a scoreboard predictor
`timescale 1ns / 100ps

module testbench;

    localparam int TABLE_DEPTH = 256;
    localparam int ITEM_TARGET = 900;
    localparam int QUIET_FROM  = 820;
    localparam int LONG_HOLD   = 500;

    class factor_scoreboard #(int DEPTH = 256);
        logic [31:0]         seen_values [DEPTH];
        int unsigned         n_distinct;
        opf_pkg::res_word_t  expected_codes [$];
        int unsigned         mismatches;

        function new();
            n_distinct = 0;
            mismatches = 0;
        endfunction

        // work out the code word for an accepted element word
        function void note_element(opf_pkg::elem_word_t w);
            opf_pkg::res_word_t want;
            int unsigned        pos;
            bit                 found;
            bit                 fresh;
            bit                 full;
            pos   = 0;
            found = 0;
            fresh = 0;
            full  = 0;
            for (int i = 0; i < n_distinct; i++)
            begin
                if (!found && seen_values[i] == w.element)
                begin
                    pos   = i;
                    found = 1;
                end
            end
            if (!found)
            begin
                if (n_distinct < DEPTH)
                begin
                    seen_values[n_distinct] = w.element;
                    pos        = n_distinct;
                    n_distinct = n_distinct + 1;
                    fresh      = 1;
                end
                else
                begin
                    full = 1;
                end
            end
            want.lookup_index = pos[7:0];
            want.is_new       = fresh;
            want.new_element  = w.element;
            want.table_full   = full;
            want.unique_count = n_distinct[8:0];
            want.last_result  = w.last_element;
            expected_codes.push_back(want);
            // table empties only after the last word's result is formed
            if (w.last_element)
                n_distinct = 0;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_code(opf_pkg::res_word_t got);
            opf_pkg::res_word_t want;
            if (expected_codes.size() == 0)
            begin
                $error("result word %h with nothing expected", got);
                mismatches++;
                return;
            end
            want = expected_codes.pop_front();
            compare_field("lookup_index", want.lookup_index, got.lookup_index);
            compare_field("is_new", want.is_new, got.is_new);
            compare_field("new_element", want.new_element, got.new_element);
            compare_field("table_full", want.table_full, got.table_full);
            compare_field("unique_count", want.unique_count, got.unique_count);
            compare_field("last_result", want.last_result, got.last_result);
        endfunction

        function int unsigned pending();
            return expected_codes.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                elem_valid;
    logic                elem_stall;
    opf_pkg::elem_word_t elem;
    logic                res_valid;
    logic                res_stall;
    opf_pkg::res_word_t  res;

    factor_scoreboard #(TABLE_DEPTH) board;
    int  items_sent;
    int  hold_left;
    bit  long_hold_done;
    bit  overflow_done;
    int  arrays_sent;

    order_preserving_factorize #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem_valid (elem_valid),
        .elem_stall (elem_stall),
        .elem       (elem),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic bit quiet();
        return items_sent >= QUIET_FROM;
    endfunction

    // receiver: random stall bursts, one long hold-off, none near the end
    initial
    begin
        res_stall      <= 1'b0;
        hold_left      = 0;
        long_hold_done = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid === 1'b1 && !res_stall)
                board.check_code(res);
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else if (!long_hold_done && items_sent >= 100)
            begin
                long_hold_done = 1;
                hold_left      = LONG_HOLD;
                res_stall      <= 1'b1;
            end
            else if (!quiet() && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(0, 3);
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
            end
        end
    end

    // offer one word, returning at the edge that takes it
    task automatic send_word(input logic [31:0] value, input logic last);
        opf_pkg::elem_word_t w;
        w.element      = value;
        w.last_element = last;
        if (!quiet() && $urandom_range(0, 3) == 0)
        begin
            elem_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        elem_valid <= 1'b1;
        elem       <= w;
        do
            @(posedge clk);
        while (elem_stall);
        board.note_element(w);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        elem_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    task automatic send_random_array();
        logic [31:0] pool [8];
        logic [31:0] v;
        int          len;
        int          psz;
        int          style;
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
        psz   = $urandom_range(1, 8);
        style = $urandom_range(0, 3);
        for (int i = 0; i < 8; i++)
        begin
            case (style)
                // small values either side of zero
                0: pool[i] = $urandom_range(0, 3) ^ {32{$urandom_range(0, 1) == 1}};
                // near the signed extremes
                1: pool[i] = ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF)
                             ^ $urandom_range(0, 1);
                default: pool[i] = $urandom();
            endcase
        end
        for (int i = 0; i < len; i++)
        begin
            v = (style == 3) ? $urandom() : pool[$urandom_range(0, psz - 1)];
            send_word(v, i == len - 1);
        end
    endtask

    // fills the table, then mixes misses on a full table with hits at both ends and in between
    task automatic send_overflow_array();
        logic [31:0] held [TABLE_DEPTH];
        logic [31:0] v;
        bit          clash;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            v      = $urandom();
            v[7:0] = i[7:0];
            held[i] = v;
            send_word(v, 1'b0);
        end
        for (int j = 0; j <= 20; j++)
        begin
            if (j % 2 == 0)
            begin
                do
                begin
                    v     = $urandom();
                    clash = 0;
                    for (int k = 0; k < TABLE_DEPTH; k++)
                        if (held[k] == v)
                            clash = 1;
                end
                while (clash);
            end
            else if (j == 1)
                v = held[TABLE_DEPTH - 1];
            else if (j == 3)
                v = held[0];
            else
                v = held[$urandom_range(0, TABLE_DEPTH - 1)];
            send_word(v, j == 20);
        end
    endtask

    initial
    begin
        board         = new();
        items_sent    = 0;
        overflow_done = 0;
        arrays_sent   = 0;
        rst_n         <= 1'b0;
        elem_valid    <= 1'b0;
        elem          <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, repeats and re-use after clearing
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0001, 1'b1);
        send_word(32'h5555_5555, 1'b1);
        send_word(32'hAAAA_AAAA, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b1);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0007, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0007, 1'b1);

        while (items_sent < ITEM_TARGET)
        begin
            if (!overflow_done && items_sent >= 300)
            begin
                send_overflow_array();
                overflow_done = 1;
                wait_for_drain();
            end
            else
            begin
                send_random_array();
            end
            arrays_sent++;
            if (arrays_sent % 25 == 0 && !quiet())
                wait_for_drain();
        end

        wait_for_drain();
        repeat (300) @(posedge clk);
        if (board.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/opf_pkg.sv
src/opf_ram.sv
src/opf_ctrl.sv
src/opf_datapath.sv
src/order_preserving_factorize.sv
src/opf_checker.sv
verif/testbench.sv
